// ----- rtl/core/mda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mda_pkg;

    localparam int COUNTER_BITS_DEF = 8;
    // deltas travel sign-extended to the widest counter supported
    localparam int DELTA_W          = 16;
    localparam int SUM_W            = 13;
    localparam int LIMIT_W          = 12;
    localparam int CALC_W           = 18;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2048;
    localparam logic [CALC_W-1:0]  PKT_LIMIT   = 18'd127;
    localparam logic [7:0]         BTN_OPEN    = 8'h87;
    localparam logic [7:0]         BTN_MARK    = 8'h80;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] OUT_SAME    = 3'd0;
    localparam logic [2:0] OUT_CHANGED = 3'd1;
    localparam logic [2:0] OUT_PACKET  = 3'd2;
    localparam logic [2:0] OUT_REFUSED = 3'd3;
    localparam logic [2:0] OUT_CLEARED = 3'd4;

    typedef struct packed {
        logic [1:0]                op;
        logic                      moved;
        logic [2:0]                btn;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } cmd_t;

    function automatic logic signed [CALC_W-1:0] clamp_sym(
        input logic signed [CALC_W-1:0] v,
        input logic signed [CALC_W-1:0] lim
    );
        logic signed [CALC_W-1:0] r;
        begin
            if (v < -lim)
            begin
                r = -lim;
            end
            else if (v > lim)
            begin
                r = lim;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mda_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mda_front
    import mda_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    output logic             push_valid,
    output cmd_t             push_cmd,
    input  wire logic        push_ready
);

    logic [COUNTER_BITS-1:0]   last_x_reg, last_x_next;
    logic [COUNTER_BITS-1:0]   last_y_reg, last_y_next;
    logic [COUNTER_BITS+7:0]   ext_x, ext_y;
    logic [COUNTER_BITS-1:0]   nx, ny;
    logic signed [COUNTER_BITS-1:0] dx_w, dy_w;
    logic                      xfer;

    assign s_tready = push_ready;
    assign xfer     = s_tvalid && s_tready;

    assign ext_x = {{COUNTER_BITS{1'b0}}, s_tdata[7:0]};
    assign ext_y = {{COUNTER_BITS{1'b0}}, s_tdata[15:8]};
    assign nx    = ext_x[COUNTER_BITS-1:0];
    assign ny    = ext_y[COUNTER_BITS-1:0];
    // wrap new minus last to a signed counter-width delta
    assign dx_w  = nx - last_x_reg;
    assign dy_w  = ny - last_y_reg;

    always_comb
    begin
        push_cmd.op    = s_tuser;
        push_cmd.moved = (dx_w != '0) || (dy_w != '0);
        push_cmd.btn   = {s_tdata[16], s_tdata[17], s_tdata[18]};
        push_cmd.dx    = DELTA_W'(dx_w);
        push_cmd.dy    = DELTA_W'(dy_w);
        // drop the unused op code here
        push_valid     = s_tvalid && (s_tuser != OP_NONE);
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        if (xfer && (s_tuser == OP_SAMPLE))
        begin
            last_x_next = nx;
            last_y_next = ny;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
        end
        else
        begin
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mda_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mda_queue
    import mda_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  cmd_t      push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mda_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mda_back
    import mda_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [LIMIT_W-1:0] accum_limit,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  cmd_t                    pop_cmd,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,
    output logic [2:0]              m_tuser
);

    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic [7:0]               btn_reg, btn_next;
    logic                     ready_reg, ready_next;
    logic                     out_valid_reg, out_valid_next;
    logic [2:0]               outcome_reg, outcome_next;
    logic [7:0]               bbyte_reg, bbyte_next;
    logic [7:0]               pdx_reg, pdx_next;
    logic [7:0]               pdy_reg, pdy_next;

    logic                     fire;
    logic signed [CALC_W-1:0] lim, sx_ext, sy_ext, new_x, new_y, pkt_x, pkt_y;

    // a free output register or a transfer this cycle frees the slot
    assign pop_ready = !out_valid_reg || m_tready;
    assign fire      = pop_valid && pop_ready;

    assign lim    = CALC_W'({1'b0, accum_limit});
    assign sx_ext = CALC_W'(sum_x_reg);
    assign sy_ext = CALC_W'(sum_y_reg);
    assign new_x  = clamp_sym(sx_ext + CALC_W'(pop_cmd.dx), lim);
    assign new_y  = clamp_sym(sy_ext - CALC_W'(pop_cmd.dy), lim);
    assign pkt_x  = clamp_sym(sx_ext, PKT_LIMIT);
    assign pkt_y  = clamp_sym(sy_ext, PKT_LIMIT);

    always_comb
    begin
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        btn_next       = btn_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg;
        outcome_next   = outcome_reg;
        bbyte_next     = bbyte_reg;
        pdx_next       = pdx_reg;
        pdy_next       = pdy_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            outcome_next   = OUT_SAME;
            bbyte_next     = '0;
            pdx_next       = '0;
            pdy_next       = '0;
            unique case (pop_cmd.op)
                OP_SAMPLE:
                begin
                    if (pop_cmd.moved || ({5'b0, pop_cmd.btn} != btn_reg))
                    begin
                        btn_next     = {5'b0, pop_cmd.btn};
                        sum_x_next   = new_x[SUM_W-1:0];
                        sum_y_next   = new_y[SUM_W-1:0];
                        ready_next   = 1'b1;
                        outcome_next = OUT_CHANGED;
                    end
                end
                OP_READ:
                begin
                    if (!ready_reg)
                    begin
                        outcome_next = OUT_REFUSED;
                    end
                    else
                    begin
                        pdx_next     = pkt_x[7:0];
                        pdy_next     = pkt_y[7:0];
                        sum_x_next   = sum_x_reg - pkt_x[SUM_W-1:0];
                        sum_y_next   = sum_y_reg - pkt_y[SUM_W-1:0];
                        bbyte_next   = btn_reg | BTN_MARK;
                        ready_next   = 1'b0;
                        outcome_next = OUT_PACKET;
                    end
                end
                OP_CLEAR:
                begin
                    sum_x_next   = '0;
                    sum_y_next   = '0;
                    btn_next     = BTN_OPEN;
                    ready_next   = 1'b0;
                    outcome_next = OUT_CLEARED;
                end
                default:
                begin
                    outcome_next = OUT_SAME;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            btn_reg       <= BTN_OPEN;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            btn_reg       <= btn_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result payload; data_ready rides on ready_reg
    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        bbyte_reg   <= bbyte_next;
        pdx_reg     <= pdx_next;
        pdy_reg     <= pdy_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = outcome_reg;
    assign m_tdata  = {7'b0, ready_reg, pdy_reg, pdx_reg, bbyte_reg};

endmodule

`default_nettype wire

// ----- rtl/core/mouse_delta_accumulator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Mouse delta accumulator.
// Input stream (s_*): tuser carries the op (sample, read packet, clear);
// tdata carries the two position counters and the three low-active pins.
// Output stream (m_*): tuser carries the outcome; tdata carries the packet
// button byte, the clamped x and y motion and the data-ready flag.
// cfg_wen/cfg_wdata write the saturation bound of the running sums.
// One item per cycle sustained while m_tready stays high. A result is
// registered: it passes through the queue and then the output register
// before it shows on m_*. An item with the unused op code is taken but
// yields no result.
// The front stage keeps the last counters and forms the wrapped deltas;
// a two-entry queue feeds the back stage, which owns the sums, button
// state and ready flag. When m_tready is low the output register holds,
// the queue fills, and s_tready drops once both queue entries are taken.
// Reset clears the counters, sums and ready flag, sets the buttons to the
// open state and the bound to 2048, and empties the queue and output.
module mouse_delta_accumulator_unit
    import mda_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // [7:0] count_x, [15:8] count_y, [16] left_pin, [17] middle_pin,
    // [18] right_pin
    input  wire logic [23:0]        s_tdata,
    // [1:0] op
    input  wire logic [1:0]         s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [7:0] button_byte, [15:8] packet_dx, [23:16] packet_dy,
    // [24] data_ready
    output logic [31:0]             m_tdata,
    // [2:0] outcome
    output logic [2:0]              m_tuser,
    input  wire logic               cfg_wen,
    input  wire logic [LIMIT_W-1:0] cfg_wdata
);

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               push_valid, push_ready;
    cmd_t               push_cmd;
    logic               pop_valid, pop_ready;
    cmd_t               pop_cmd;

    assign limit_next = cfg_wen ? cfg_wdata : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    mda_front #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    mda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    mda_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .accum_limit (limit_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire
